@@ src/hats_pkg.sv @@
// ----------------------------------------------------------------------------
// hats_pkg
// Shared constants, stage map and the sRGB encode threshold table.
// ----------------------------------------------------------------------------
package hats_pkg;

    localparam int TABLE_FRAC_BITS = 12;
    localparam int EXP_W           = 16;
    localparam int EXP_FRAC_BITS   = 12;
    localparam logic [EXP_W-1:0] EXPOSURE_RESET = 16'd7373;

    localparam int V_W       = TABLE_FRAC_BITS + 1;
    localparam int TH_W      = TABLE_FRAC_BITS + 2;
    localparam int DIV_STEPS = TABLE_FRAC_BITS + 1;
    localparam int SRCH_STEPS = 8;
    localparam logic [V_W-1:0] TABLE_ONE = V_W'(1) << TABLE_FRAC_BITS;

    // stage map
    localparam int ST_MUL  = 0;
    localparam int ST_CMP  = 1;
    localparam int ST_DIV  = 2;
    localparam int ST_RND  = ST_DIV + DIV_STEPS;
    localparam int ST_SRCH = ST_RND + 1;
    localparam int NSTG    = ST_SRCH + SRCH_STEPS;

    typedef struct packed {
        logic [NSTG-1:0] en;
    } t_stage_ctl;

    localparam int BIG_W = 320;
    typedef logic [TH_W-1:0] t_th_tab [256];
    localparam logic [TH_W-1:0] TH_NONE = TH_W'(TABLE_ONE) + TH_W'(1);

    // (400k+5410)^12 * 32^TABLE_FRAC_BITS
    function automatic logic [BIG_W-1:0] big_thr(input int unsigned k);
        logic [BIG_W-1:0] r;
        r = BIG_W'(1);
        for (int i = 0; i < 12; i++) begin
            r = r * BIG_W'(400 * k + 5410);
        end
        for (int i = 0; i < TABLE_FRAC_BITS; i++) begin
            r = r * BIG_W'(32);
        end
        return r;
    endfunction

    // th[k] = smallest code v whose encoded byte is at least k
    function automatic t_th_tab build_thresholds();
        t_th_tab th;
        logic [BIG_W-1:0] c;
        logic [BIG_W-1:0] lhs;
        logic [BIG_W-1:0] rhs;
        int unsigned k;
        int unsigned b;
        int unsigned hi;
        longint unsigned lb;
        for (int j = 0; j < 256; j++) begin
            th[j] = TH_NONE;
        end
        th[0] = '0;
        c = BIG_W'(1);
        for (int i = 0; i < 12; i++) begin
            c = c * BIG_W'(107610);
        end
        k   = 1;
        rhs = big_thr(1);
        hi  = 0;
        for (int unsigned v = 0; v <= (1 << TABLE_FRAC_BITS); v++) begin
            if (64'(v) * 64'd10000000 <= (64'd31308 << TABLE_FRAC_BITS)) begin
                // rounded linear segment, quotient found by counting up
                lb = 64'd65892 * 64'(v) + (64'd10 << TABLE_FRAC_BITS);
                b  = 0;
                while (b < 255 && 64'(b + 1) * (64'd20 << TABLE_FRAC_BITS) <= lb) begin
                    b++;
                end
            end else begin
                lhs = c;
                for (int i = 0; i < 5; i++) begin
                    lhs = lhs * BIG_W'(v);
                end
                while (k <= 255 && lhs >= rhs) begin
                    k++;
                    if (k <= 255) begin
                        rhs = big_thr(k);
                    end
                end
                b = k - 1;
            end
            for (int unsigned j = hi + 1; j <= b; j++) begin
                th[j] = TH_W'(v);
            end
            if (b > hi) begin
                hi = b;
            end
        end
        return th;
    endfunction

    localparam t_th_tab TH_TAB = build_thresholds();

endpackage

@@ src/hats_lane.sv @@
// ----------------------------------------------------------------------------
// hats_lane
// One color channel: exposure multiply, bit-serial pipelined divide by the
// sample count, rounding/clamp, and an 8-step pipelined threshold search.
// ----------------------------------------------------------------------------
module hats_lane #(
    parameter int SUM_W     = 36,
    parameter int CNT_W     = 16,
    parameter int FRAC_BITS = 12
) (
    input  logic                        i_clk,
    input  hats_pkg::t_stage_ctl        i_ctl,
    input  logic [SUM_W-1:0]            i_sum,
    input  logic [CNT_W-1:0]            i_cnt,
    input  logic [hats_pkg::EXP_W-1:0]  i_gain,
    output logic [7:0]                  o_byte
);
    import hats_pkg::*;

    localparam int P_W   = SUM_W + EXP_W;
    localparam int SH    = FRAC_BITS + EXP_FRAC_BITS;
    localparam int D_W   = CNT_W + SH;
    localparam int CMP_W = (P_W > D_W) ? P_W : D_W;

    logic [P_W-1:0] r_prod;
    logic [D_W-1:0] r_den0;

    logic [D_W-1:0]       r_rem  [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo  [DIV_STEPS+1];
    logic [D_W-1:0]       r_den  [DIV_STEPS];
    logic                 r_over [DIV_STEPS+1];

    logic [V_W-1:0] r_v   [SRCH_STEPS];
    logic [7:0]     r_acc [SRCH_STEPS+1];

    logic           n_over;
    logic [V_W:0]   n_qr;
    logic [V_W-1:0] n_v;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_MUL]) begin
            r_prod <= P_W'(i_sum) * P_W'(i_gain);
            r_den0 <= D_W'(i_cnt) << SH;
        end
    end

    assign n_over = CMP_W'(r_prod) >= CMP_W'(r_den0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_CMP]) begin
            r_over[0] <= n_over;
            r_rem[0]  <= n_over ? '0 : r_prod[D_W-1:0];
            r_quo[0]  <= '0;
            r_den[0]  <= r_den0;
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        logic [D_W:0] n_rs;
        logic         n_ge;
        assign n_rs = {r_rem[i], 1'b0};
        assign n_ge = n_rs >= {1'b0, r_den[i]};
        always_ff @(posedge i_clk) begin
            if (i_ctl.en[ST_DIV+i]) begin
                r_quo[i+1]  <= {r_quo[i][DIV_STEPS-2:0], n_ge};
                r_over[i+1] <= r_over[i];
            end
        end
        if (i < DIV_STEPS - 1) begin : g_fwd
            logic [D_W-1:0] n_df;
            assign n_df = n_rs[D_W-1:0] - r_den[i];
            always_ff @(posedge i_clk) begin
                if (i_ctl.en[ST_DIV+i]) begin
                    r_rem[i+1] <= n_ge ? n_df : n_rs[D_W-1:0];
                    r_den[i+1] <= r_den[i];
                end
            end
        end
    end

    assign n_qr = ({1'b0, r_quo[DIV_STEPS]} + (V_W+1)'(1)) >> 1;
    assign n_v  = (r_over[DIV_STEPS] || n_qr > (V_W+1)'(TABLE_ONE)) ?
                  TABLE_ONE : n_qr[V_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_RND]) begin
            r_v[0]   <= n_v;
            r_acc[0] <= '0;
        end
    end

    for (genvar j = 0; j < SRCH_STEPS; j++) begin : g_srch
        logic [7:0] n_cand;
        logic       n_hit;
        assign n_cand = r_acc[j] | (8'd1 << (SRCH_STEPS - 1 - j));
        assign n_hit  = TH_TAB[n_cand] <= {1'b0, r_v[j]};
        always_ff @(posedge i_clk) begin
            if (i_ctl.en[ST_SRCH+j]) begin
                r_acc[j+1] <= n_hit ? n_cand : r_acc[j];
            end
        end
        if (j < SRCH_STEPS - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_ctl.en[ST_SRCH+j]) begin
                    r_v[j+1] <= r_v[j];
                end
            end
        end
    end

    assign o_byte = r_acc[SRCH_STEPS];

endmodule

@@ src/hdr_average_tonemap_srgb.sv @@
// ----------------------------------------------------------------------------
// hdr_average_tonemap_srgb
// Averages three radiance sums by sample count, applies exposure, clamps and
// sRGB-encodes each channel to a rounded byte.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// in      | i_valid / o_stall   | i_sum_red, i_sum_green, i_sum_blue, i_sample_count
// out     | o_valid / i_stall   | o_red_byte, o_green_byte, o_blue_byte
// cfg     | i_cfg_wr_en         | i_cfg_wr_data (exposure gain, 4.12)
//
// One request per cycle unless o_stall is raised; the stages are multiply,
// compare, 13 divide steps, round and 8 search steps.
// Each stage advances when empty or when the next one advances, so bubbles
// close up under an output stall. Reset clears valid bits and loads the
// reset gain.
// ----------------------------------------------------------------------------
module hdr_average_tonemap_srgb #(
    parameter int SUM_INT_BITS = 24,
    parameter int FRAC_BITS    = 12,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [hats_pkg::EXP_W-1:0]           i_cfg_wr_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [SUM_INT_BITS+FRAC_BITS-1:0]    i_sum_red,
    input  logic [SUM_INT_BITS+FRAC_BITS-1:0]    i_sum_green,
    input  logic [SUM_INT_BITS+FRAC_BITS-1:0]    i_sum_blue,
    input  logic [COUNT_WIDTH-1:0]               i_sample_count,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [7:0]                           o_red_byte,
    output logic [7:0]                           o_green_byte,
    output logic [7:0]                           o_blue_byte
);
    import hats_pkg::*;

    localparam int SUM_W = SUM_INT_BITS + FRAC_BITS;

    logic [EXP_W-1:0]   r_gain;
    logic [NSTG-1:0]    r_vld;
    logic [NSTG-1:0]    n_vld_in;
    logic [NSTG:0]      n_en;
    t_stage_ctl         n_ctl;
    logic [COUNT_WIDTH-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= EXPOSURE_RESET;
        end else if (i_cfg_wr_en) begin
            r_gain <= i_cfg_wr_data;
        end
    end

    assign n_en[NSTG] = !i_stall;
    for (genvar s = 0; s < NSTG; s++) begin : g_en
        assign n_en[s] = !r_vld[s] || n_en[s+1];
    end
    assign n_ctl.en = n_en[NSTG-1:0];
    assign n_vld_in = {r_vld[NSTG-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NSTG; s++) begin
                if (n_en[s]) begin
                    r_vld[s] <= n_vld_in[s];
                end
            end
        end
    end

    assign o_stall = !n_en[0];
    assign o_valid = r_vld[NSTG-1];
    assign n_cnt   = (i_sample_count == '0) ? COUNT_WIDTH'(1) : i_sample_count;

    hats_lane #(.SUM_W(SUM_W), .CNT_W(COUNT_WIDTH), .FRAC_BITS(FRAC_BITS)) u_red (
        .i_clk (i_clk), .i_ctl (n_ctl), .i_sum (i_sum_red),
        .i_cnt (n_cnt), .i_gain (r_gain), .o_byte (o_red_byte)
    );

    hats_lane #(.SUM_W(SUM_W), .CNT_W(COUNT_WIDTH), .FRAC_BITS(FRAC_BITS)) u_green (
        .i_clk (i_clk), .i_ctl (n_ctl), .i_sum (i_sum_green),
        .i_cnt (n_cnt), .i_gain (r_gain), .o_byte (o_green_byte)
    );

    hats_lane #(.SUM_W(SUM_W), .CNT_W(COUNT_WIDTH), .FRAC_BITS(FRAC_BITS)) u_blue (
        .i_clk (i_clk), .i_ctl (n_ctl), .i_sum (i_sum_blue),
        .i_cnt (n_cnt), .i_gain (r_gain), .o_byte (o_blue_byte)
    );

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked output");

    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted request not in first stage");

endmodule

@@ bench/hdr_tonemap_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_tonemap_checker
// Watches the request, result and gain write ports of the tone mapper,
// predicts each pixel's sRGB bytes with an exact integer encode table and
// compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module hdr_tonemap_checker #(
    parameter int SUM_W = 36,
    parameter int CNT_W = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [hats_pkg::EXP_W-1:0]    i_cfg_wr_data,
    input  logic                          i_valid,
    input  logic                          i_in_stall,
    input  logic [SUM_W-1:0]              i_sum_red,
    input  logic [SUM_W-1:0]              i_sum_green,
    input  logic [SUM_W-1:0]              i_sum_blue,
    input  logic [CNT_W-1:0]              i_sample_count,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [7:0]                    i_red_byte,
    input  logic [7:0]                    i_green_byte,
    input  logic [7:0]                    i_blue_byte,
    output int                            o_fail_count,
    output int                            o_pending
);
    localparam int ONE = 1 << hats_pkg::TABLE_FRAC_BITS;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    logic [7:0]              srgb_lut [0:ONE];
    logic [319:0]            byte_thr [1:255];
    logic [hats_pkg::EXP_W-1:0] gain;
    t_pixel                  pixel_q [$];

    initial begin
        logic [319:0] c;
        logic [319:0] lhs;
        logic [63:0]  lin;
        int unsigned  k;
        c = 320'd1;
        for (int i = 0; i < 12; i++) c = c * 320'd107610;
        for (int j = 1; j <= 255; j++) begin
            byte_thr[j] = 320'd1;
            for (int i = 0; i < 12; i++) byte_thr[j] = byte_thr[j] * 320'(400 * j + 5410);
            byte_thr[j] = byte_thr[j] << (5 * hats_pkg::TABLE_FRAC_BITS);
        end
        k = 1;
        for (int v = 0; v <= ONE; v++) begin
            if (64'(v) * 64'd10000000 <= (64'd31308 << hats_pkg::TABLE_FRAC_BITS)) begin
                lin = (64'd65892 * 64'(v) + (64'd10 << hats_pkg::TABLE_FRAC_BITS)) /
                      (64'd20 << hats_pkg::TABLE_FRAC_BITS);
                srgb_lut[v] = (lin > 64'd255) ? 8'd255 : lin[7:0];
            end else begin
                lhs = c;
                for (int i = 0; i < 5; i++) lhs = lhs * 320'(v);
                while (k <= 255 && lhs >= byte_thr[k]) k++;
                srgb_lut[v] = 8'(k - 1);
            end
        end
    end

    function automatic logic [7:0] encode(input logic [SUM_W-1:0] sum,
                                          input logic [CNT_W:0] cnt);
        logic [79:0] prod;
        logic [79:0] den;
        logic [79:0] q;
        logic [79:0] code;
        prod = 80'(sum) * 80'(gain);
        den  = 80'(cnt) << (12 + hats_pkg::EXP_FRAC_BITS);
        if (prod >= den) return srgb_lut[ONE];
        q    = (prod << (hats_pkg::TABLE_FRAC_BITS + 1)) / den;
        code = (q + 80'd1) >> 1;
        if (code > 80'(ONE)) code = 80'(ONE);
        return srgb_lut[code];
    endfunction

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    assign o_pending = pixel_q.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_pixel     p;
        logic [CNT_W:0] cnt;
        if (!i_rst_n) begin
            gain <= hats_pkg::EXPOSURE_RESET;
        end else begin
            if (i_cfg_wr_en) gain <= i_cfg_wr_data;
            if (i_valid && !i_in_stall) begin
                cnt = (i_sample_count == '0) ? (CNT_W+1)'(1) : (CNT_W+1)'(i_sample_count);
                p.red   = encode(i_sum_red, cnt);
                p.green = encode(i_sum_green, cnt);
                p.blue  = encode(i_sum_blue, cnt);
                pixel_q.push_back(p);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    $display("unexpected result at %0t", $time);
                    o_fail_count++;
                end else begin
                    p = pixel_q.pop_front();
                    if (i_red_byte !== p.red) report("red", i_red_byte, p.red);
                    if (i_green_byte !== p.green) report("green", i_green_byte, p.green);
                    if (i_blue_byte !== p.blue) report("blue", i_blue_byte, p.blue);
                end
            end
        end
    end
endmodule

@@ bench/tb_hdr_average_tonemap_srgb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdr_average_tonemap_srgb
// Drives bursts of pixel requests through several exposure settings, with a
// stalling receiver and one long hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_hdr_average_tonemap_srgb;
    localparam int SUM_W = 36;
    localparam int CNT_W = 16;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [hats_pkg::EXP_W-1:0] i_cfg_wr_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [SUM_W-1:0]           i_sum_red = '0;
    logic [SUM_W-1:0]           i_sum_green = '0;
    logic [SUM_W-1:0]           i_sum_blue = '0;
    logic [CNT_W-1:0]           i_sample_count = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [7:0]                 o_red_byte;
    logic [7:0]                 o_green_byte;
    logic [7:0]                 o_blue_byte;
    int                         fail_count;
    int                         pending;
    int                         burst_left = 0;
    logic                       hold_go = 1'b0;

    always #1 i_clk = ~i_clk;

    hdr_average_tonemap_srgb u_dut (.*);

    hdr_tonemap_checker #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_checker (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_wr_data, .i_valid,
        .i_in_stall(o_stall), .i_sum_red, .i_sum_green, .i_sum_blue, .i_sample_count,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_red_byte(o_red_byte),
        .i_green_byte(o_green_byte), .i_blue_byte(o_blue_byte),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // receiver: stall pattern per segment, one long hold when asked
    initial begin
        int pct;
        @(posedge i_rst_n);
        forever begin
            if (hold_go) begin
                hold_go = 1'b0;
                for (int n = 0; n < 300; n++) begin
                    @(negedge i_clk);
                    i_stall = 1'b1;
                end
            end
            case ($urandom_range(0, 3))
                0: pct = 0;
                1: pct = 25;
                2: pct = 50;
                default: pct = 90;
            endcase
            repeat ($urandom_range(10, 80)) begin
                @(negedge i_clk);
                i_stall = ($urandom_range(0, 99) < pct);
            end
        end
    end

    function automatic logic [SUM_W-1:0] rand_sum();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return SUM_W'(r) >> $urandom_range(0, SUM_W);
    endfunction

    task automatic send(input logic [SUM_W-1:0] r, input logic [SUM_W-1:0] g,
                        input logic [SUM_W-1:0] b, input logic [CNT_W-1:0] c);
        logic took;
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid = 1'b1;
        i_sum_red = r;
        i_sum_green = g;
        i_sum_blue = b;
        i_sample_count = c;
        do begin
            @(posedge i_clk);
            took = !o_stall;
            @(negedge i_clk);
        end while (!took);
    endtask

    task automatic set_gain(input logic [hats_pkg::EXP_W-1:0] g);
        i_valid = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = g;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    initial begin
        logic [SUM_W-1:0] full;
        logic [hats_pkg::EXP_W-1:0] gains [6];
        logic [CNT_W-1:0] c;
        full = '1;
        gains = '{16'd7373, 16'd0, 16'hFFFF, 16'd4096, 16'd1, 16'd7373};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, zero count, linear-to-power knee, clamp
        send('0, '0, '0, '0);
        send(full, full, full, '1);
        send(full, '0, 36'h1000, '0);
        send(36'h1000, 36'h800, 36'h8FF, 16'd1);
        send(36'd7, 36'd12, 36'd13, 16'd1);
        send(36'd20, 36'd30, 36'd40, 16'd1);
        send(36'h5555_5555_5, 36'hA_AAAA_AAAA, 36'h1234_5678_9, 16'h8000);
        send(36'hFFF, 36'h1000, 36'h1001, 16'd2);
        send(36'd1, 36'd2, 36'd3, 16'hFFFF);
        send(36'h1000 * 36'd1000, 36'h7FF * 36'd1000, 36'd1000, 16'd1000);

        for (int ph = 0; ph < 6; ph++) begin
            set_gain(gains[ph]);
            for (int n = 0; n < 135; n++) begin
                if (ph == 2 && n == 40) hold_go = 1'b1;
                c = CNT_W'({$urandom} >> $urandom_range(16, 32));
                if ($urandom_range(0, 3) == 0) begin
                    send(rand_sum(), rand_sum(), rand_sum(), c);
                end else begin
                    // sums near the useful range for this count
                    send(SUM_W'(c) * SUM_W'($urandom_range(0, 9000)),
                         SUM_W'(c) * SUM_W'($urandom_range(0, 3000)),
                         SUM_W'(c) * SUM_W'($urandom_range(0, 60)), c);
                end
            end
        end

        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
